FILE: hw/rtl/pnc_pkg.sv
// Shared constants, types and the fixed palette table of the nearest-colour quantiser.
package pnc_pkg;

  localparam int unsigned COMP_W           = 8;
  localparam int unsigned IDX_W            = 4;
  localparam int unsigned ROM_ENTRIES      = 16;
  localparam int unsigned PALETTE_SIZE_DEF = 16;
  localparam int unsigned SQ_W             = 2 * COMP_W;
  localparam int unsigned WGT_W            = 11;
  localparam int unsigned PROD_W           = WGT_W + SQ_W;
  localparam int unsigned DIST_W           = 29;
  localparam int unsigned WR_BASE          = 1024;
  localparam int unsigned WB_BASE          = 1534;
  localparam int unsigned DG_SHIFT         = 11;

  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } rgb_t;

  function automatic rgb_t pal_color(input int unsigned k);
    rgb_t c;
    case (k)
      0:       c = '{8'd209, 8'd214, 8'd215};
      1:       c = '{8'd211, 8'd105, 8'd41};
      2:       c = '{8'd157, 8'd58,  8'd155};
      3:       c = '{8'd65,  8'd136, 8'd194};
      4:       c = '{8'd232, 8'd178, 8'd63};
      5:       c = '{8'd114, 8'd168, 8'd54};
      6:       c = '{8'd201, 8'd109, 8'd144};
      7:       c = '{8'd53,  8'd56,  8'd60};
      8:       c = '{8'd125, 8'd125, 8'd116};
      9:       c = '{8'd53,  8'd118, 8'd134};
      10:      c = '{8'd92,  8'd36,  8'd152};
      11:      c = '{8'd41,  8'd48,  8'd139};
      12:      c = '{8'd92,  8'd60,  8'd33};
      13:      c = '{8'd76,  8'd90,  8'd40};
      14:      c = '{8'd133, 8'd40,  8'd35};
      15:      c = '{8'd1,   8'd1,   8'd1};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/pnc_dist_lane.sv
// Three-stage redmean distance lane for one fixed palette colour.
module pnc_dist_lane #(
  parameter int unsigned LANE_IDX = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  pnc_pkg::rgb_t               pix,
  output logic [pnc_pkg::DIST_W-1:0]  lane_dist
);
  import pnc_pkg::*;

  localparam rgb_t PAL = pal_color(LANE_IDX);

  logic [COMP_W-1:0] dr, dg, db;
  logic [COMP_W:0]   rsum;
  logic [SQ_W-1:0]   dr2_nxt, dg2_nxt, db2_nxt;
  logic [WGT_W-1:0]  wr_nxt, wb_nxt;
  logic [SQ_W-1:0]   dr2_r, dg2_r, db2_r;
  logic [WGT_W-1:0]  wr_r, wb_r;
  logic [PROD_W-1:0] pr_nxt, pg_nxt, pb_nxt;
  logic [PROD_W-1:0] pr_r, pg_r, pb_r;
  logic [DIST_W-1:0] dist_nxt, dist_r;

  always_comb begin
    dr      = (pix.r >= PAL.r) ? (pix.r - PAL.r) : (PAL.r - pix.r);
    dg      = (pix.g >= PAL.g) ? (pix.g - PAL.g) : (PAL.g - pix.g);
    db      = (pix.b >= PAL.b) ? (pix.b - PAL.b) : (PAL.b - pix.b);
    rsum    = {1'b0, pix.r} + {1'b0, PAL.r};
    dr2_nxt = SQ_W'(dr) * SQ_W'(dr);
    dg2_nxt = SQ_W'(dg) * SQ_W'(dg);
    db2_nxt = SQ_W'(db) * SQ_W'(db);
    wr_nxt  = WGT_W'(WR_BASE) + WGT_W'(rsum);
    // The blue weight never goes below 1024, as the red sum tops out at 510.
    wb_nxt  = WGT_W'(WB_BASE) - WGT_W'(rsum);
  end

  always_comb begin
    pr_nxt = PROD_W'(wr_r) * PROD_W'(dr2_r);
    pb_nxt = PROD_W'(wb_r) * PROD_W'(db2_r);
    pg_nxt = PROD_W'(dg2_r) << DG_SHIFT;
  end

  assign dist_nxt = DIST_W'(pr_r) + DIST_W'(pg_r) + DIST_W'(pb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dr2_r  <= dr2_nxt;
      dg2_r  <= dg2_nxt;
      db2_r  <= db2_nxt;
      wr_r   <= wr_nxt;
      wb_r   <= wb_nxt;
      pr_r   <= pr_nxt;
      pg_r   <= pg_nxt;
      pb_r   <= pb_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign lane_dist = dist_r;

endmodule

FILE: hw/rtl/pnc_min_tree.sv
// Registered binary minimum tree, one compare level per stage, lower index kept on ties.
module pnc_min_tree #(
  parameter int unsigned LEAVES = 16
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [LEAVES-1:0][pnc_pkg::DIST_W-1:0]  leaf_dist,
  output logic [$clog2(LEAVES)-1:0]               best_idx
);
  import pnc_pkg::*;

  localparam int unsigned IW = $clog2(LEAVES);

  // Heap numbering: node n is fed by nodes 2n and 2n+1, the leaves sit at LEAVES and above.
  logic [DIST_W-1:0] node_d [1:2*LEAVES-1];
  logic [IW-1:0]     node_i [1:2*LEAVES-1];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    assign node_d[LEAVES+k] = leaf_dist[k];
    assign node_i[LEAVES+k] = IW'(k);
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic          take_hi;
    logic [DIST_W-1:0] d_r;
    logic [IW-1:0]     i_r;

    assign take_hi = node_d[2*n+1] < node_d[2*n];

    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= take_hi ? node_d[2*n+1] : node_d[2*n];
        i_r <= take_hi ? node_i[2*n+1] : node_i[2*n];
      end
    end

    assign node_d[n] = d_r;
    assign node_i[n] = i_r;
  end

  assign best_idx = node_i[1];

endmodule

FILE: hw/rtl/palette_nearest_color_top.sv
// Top level of the redmean nearest-palette-colour quantiser.
//
//   channel  ports                                direction  word
//   in       in_valid in_ready in_red/green/blue  sink       one RGB pixel
//   out      out_valid out_ready out_palette_index source    nearest palette index
//
// One word is taken per clock while no out_ready stall holds the pipe; the stages are
// an input register, three stages per lane (squares, weighted products, sum) and one
// registered compare level of the minimum tree per stage.
// Every stage moves together; a stall of out_ready freezes the whole pipe and drops
// in_ready in the same cycle, so nothing is lost or repeated.
// The synchronous active-low reset clears only the valid bits.
module palette_nearest_color_top #(
  parameter int unsigned PALETTE_SIZE = pnc_pkg::PALETTE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pnc_pkg::COMP_W-1:0]  in_red,
  input  logic [pnc_pkg::COMP_W-1:0]  in_green,
  input  logic [pnc_pkg::COMP_W-1:0]  in_blue,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pnc_pkg::IDX_W-1:0]   out_palette_index
);
  import pnc_pkg::*;

  localparam int unsigned LANES  = (PALETTE_SIZE < ROM_ENTRIES) ? PALETTE_SIZE : ROM_ENTRIES;
  localparam int unsigned LEVELS = $clog2(LANES);
  localparam int unsigned LEAVES = 1 << LEVELS;
  localparam int unsigned DEPTH  = 4 + LEVELS;

  logic                           en;
  logic [DEPTH-1:0]               vld_r;
  rgb_t                           pix_r;
  logic [LEAVES-1:0][DIST_W-1:0]  lane_dist;
  logic [LEVELS-1:0]              best_idx;

  assign en       = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= '{in_red, in_green, in_blue};
    end
  end

  for (genvar k = 0; k < LEAVES; k++) begin : g_lane
    if (k < LANES) begin : g_real
      pnc_dist_lane #(
        .LANE_IDX (k)
      ) u_lane (
        .clk       (clk),
        .en        (en),
        .pix       (pix_r),
        .lane_dist (lane_dist[k])
      );
    end else begin : g_pad
      // Padding leaves sit above every reachable distance, so they never win.
      assign lane_dist[k] = '1;
    end
  end

  pnc_min_tree #(
    .LEAVES (LEAVES)
  ) u_tree (
    .clk       (clk),
    .en        (en),
    .leaf_dist (lane_dist),
    .best_idx  (best_idx)
  );

  assign out_valid         = vld_r[DEPTH-1];
  assign out_palette_index = IDX_W'(best_idx);

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the redmean nearest-palette-colour quantiser.
`timescale 1ns / 1ps

module testbench;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [pnc_pkg::COMP_W-1:0]    in_red = '0;
  logic [pnc_pkg::COMP_W-1:0]    in_green = '0;
  logic [pnc_pkg::COMP_W-1:0]    in_blue = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pnc_pkg::IDX_W-1:0]     out_palette_index;

  // Percentages of cycles in which each side holds back.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned pixels_sent = 0;
  int unsigned indices_checked = 0;
  int unsigned fail_count = 0;

  logic [pnc_pkg::IDX_W-1:0] pending_index[$];

  palette_nearest_color_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index)
  );

  always #5 clk = ~clk;

  // Independent copy of the palette, packed as {red, green, blue}.
  function automatic logic [23:0] palette_rgb(input int unsigned k);
    logic [23:0] c;
    case (k)
      0:       c = {8'd209, 8'd214, 8'd215};
      1:       c = {8'd211, 8'd105, 8'd41};
      2:       c = {8'd157, 8'd58,  8'd155};
      3:       c = {8'd65,  8'd136, 8'd194};
      4:       c = {8'd232, 8'd178, 8'd63};
      5:       c = {8'd114, 8'd168, 8'd54};
      6:       c = {8'd201, 8'd109, 8'd144};
      7:       c = {8'd53,  8'd56,  8'd60};
      8:       c = {8'd125, 8'd125, 8'd116};
      9:       c = {8'd53,  8'd118, 8'd134};
      10:      c = {8'd92,  8'd36,  8'd152};
      11:      c = {8'd41,  8'd48,  8'd139};
      12:      c = {8'd92,  8'd60,  8'd33};
      13:      c = {8'd76,  8'd90,  8'd40};
      14:      c = {8'd133, 8'd40,  8'd35};
      default: c = {8'd1,   8'd1,   8'd1};
    endcase
    return c;
  endfunction

  function automatic int unsigned square_of_gap(input int unsigned a, input int unsigned b);
    int unsigned d;
    d = (a >= b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // Weighted redmean distance scaled by 512; the strictly smaller distance wins,
  // so the lowest index is kept on a tie.
  function automatic logic [pnc_pkg::IDX_W-1:0] nearest_index(
    input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    logic [23:0] c;
    int unsigned rsum;
    bit   [31:0] cand_dist;
    bit   [31:0] best_dist;
    int unsigned best;
    best = 0;
    best_dist = '1;
    for (int unsigned k = 0; k < pnc_pkg::ROM_ENTRIES; k++) begin
      c = palette_rgb(k);
      rsum = int'(r) + int'(c[23:16]);
      cand_dist = (1024 + rsum) * square_of_gap(r, c[23:16])
                + 2048 * square_of_gap(g, c[15:8])
                + (1534 - rsum) * square_of_gap(b, c[7:0]);
      if (k == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best = k;
      end
    end
    return best[pnc_pkg::IDX_W-1:0];
  endfunction

  // Offers one pixel word and holds it until the block takes it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (!in_ready);
    pending_index.push_back(nearest_index(r, g, b));
    pixels_sent++;
  endtask

  // Holds the sender back until every outstanding index has come out.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_index.size() == 0) begin
        $error("palette_index: unexpected word, got %0d", out_palette_index);
        fail_count++;
      end else begin
        if (out_palette_index !== pending_index[0]) begin
          $error("palette_index mismatch: expected %0d, got %0d",
                 pending_index[0], out_palette_index);
          fail_count++;
        end
        void'(pending_index.pop_front());
        indices_checked++;
      end
    end
  end

  task automatic test_palette_entries();
    logic [23:0] c;
    for (int unsigned k = 0; k < pnc_pkg::ROM_ENTRIES; k++) begin
      c = palette_rgb(k);
      send_pixel(c[23:16], c[15:8], c[7:0]);
    end
  endtask

  task automatic test_extremes();
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
  endtask

  // Entries 7 and 9 share their red value, so green 87 and blue 97 sit exactly
  // halfway between them and the two distances are equal for any red.
  task automatic test_tie_break();
    send_pixel(8'd53, 8'd87, 8'd97);
    send_pixel(8'd45, 8'd87, 8'd97);
    send_pixel(8'd60, 8'd87, 8'd97);
  endtask

  function automatic logic [7:0] jitter(input logic [7:0] v, input int unsigned span);
    int signed t;
    t = int'(v) + int'($urandom_range(0, 2 * span)) - int'(span);
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic test_random_pixels(input int unsigned count);
    logic [23:0] c;
    logic [23:0] d;
    logic [7:0]  r, g, b;
    for (int unsigned n = 0; n < count; n++) begin
      c = palette_rgb($urandom_range(0, 15));
      d = palette_rgb($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        end
        4, 5, 6: begin
          r = jitter(c[23:16], 8); g = jitter(c[15:8], 8); b = jitter(c[7:0], 8);
        end
        7: begin
          r = 8'($urandom); g = 8'd87; b = 8'd97;
        end
        8: begin
          // Near the boundary between two entries, where the choice is close.
          r = jitter(8'(({1'b0, c[23:16]} + {1'b0, d[23:16]}) >> 1), 2);
          g = jitter(8'(({1'b0, c[15:8]} + {1'b0, d[15:8]}) >> 1), 2);
          b = jitter(8'(({1'b0, c[7:0]} + {1'b0, d[7:0]}) >> 1), 2);
        end
        default: begin
          r = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
          g = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
          b = ($urandom_range(0, 2) == 0) ? 8'd0 : (($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom));
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 16;
    receiver_stall_pct = 58;
    test_palette_entries();
    test_extremes();
    test_tie_break();
    test_random_pixels(620);
    drain_pipe();

    sender_idle_pct = 58;
    receiver_stall_pct = 16;
    test_random_pixels(650);
    drain_pipe();

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    test_random_pixels(655);
    drain_pipe();

    // Any stray word after the last expected one is caught here.
    repeat (16) @(posedge clk);

    $display("Covered %0d pixels: every palette colour, component extremes, equal-distance ties",
             pixels_sent);
    $display("and random traffic under three idling patterns; %0d indices checked, %0d errors.",
             indices_checked, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d indices still outstanding.", pending_index.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
